[rtl/mspid_pkg.sv]
`timescale 1ns / 1ps

package mspid_pkg;

	// Field widths.
	localparam int unsigned SpeedW  = 16;
	localparam int unsigned DutyW   = 16;
	localparam int unsigned GainW   = 16;
	localparam int unsigned LimW    = 23;
	localparam int unsigned FullSpW = 8;
	localparam int unsigned ErrW    = 17;
	localparam int unsigned SumW    = 25;
	localparam int unsigned DiffW   = 18;
	localparam int unsigned CfgDW   = 23;
	localparam int unsigned CfgAW   = 3;

	// Shared multiplier operand and product widths.
	localparam int unsigned MulAW = GainW + 1;
	localparam int unsigned MulBW = 26;
	localparam int unsigned ProdW = MulAW + MulBW;

	// Register indexes on the configuration port.
	localparam logic [CfgAW-1:0] RegGainP     = 3'd0;
	localparam logic [CfgAW-1:0] RegGainI     = 3'd1;
	localparam logic [CfgAW-1:0] RegGainD     = 3'd2;
	localparam logic [CfgAW-1:0] RegIntLimit  = 3'd3;
	localparam logic [CfgAW-1:0] RegDutyMax   = 3'd4;
	localparam logic [CfgAW-1:0] RegSpeedThr  = 3'd5;
	localparam logic [CfgAW-1:0] RegFullSpeed = 3'd6;

	// Register values after reset.
	localparam logic [GainW-1:0]   RstGainP     = 16'd8192;
	localparam logic [GainW-1:0]   RstGainI     = 16'd205;
	localparam logic [GainW-1:0]   RstGainD     = 16'd82;
	localparam logic [LimW-1:0]    RstIntLimit  = 23'd256000;
	localparam logic [DutyW-1:0]   RstDutyMax   = 16'd64879;
	localparam logic [SpeedW-1:0]  RstSpeedThr  = 16'd256;
	localparam logic [FullSpW-1:0] RstFullSpeed = 8'd100;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_TGT,
		ST_ERR,
		ST_CLAMP,
		ST_MULP,
		ST_MULI,
		ST_MULD,
		ST_SUM,
		ST_SAT
	} state_t;

endpackage

[rtl/motor_speed_match_pid_unit.sv]
`timescale 1ns / 1ps

// Channel  | Signals                         | Contents (lowest bit first)
// ---------+---------------------------------+-------------------------------------------
// input    | s_tvalid s_tready s_tdata s_tuser | tdata: left_speed, right_speed, right_duty
//          |                                 | tuser: obstacle
// output   | m_tvalid m_tready m_tdata       | tdata: duty_level
// config   | cfg_we cfg_addr cfg_data        | index 0..6, write only
//
// An item without obstacle runs the steps TGT, ERR, CLAMP, MULP, MULI, MULD, SUM and SAT
// until its result is loaded; TGT and the MUL steps use the single shared multiplier. The
// next item can follow in the cycle after that load. Obstacle items are absorbed, no result.
// The output register holds a finished transaction while the next item is processed;
// the sequencer waits in its last step while that register is full and not drained.
// Reset (arst_n low) restores the register defaults and clears integral and previous error.

module motor_speed_match_pid_unit
	import mspid_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [47:0]       s_tdata,   // left_speed[15:0], right_speed[31:16], right_duty[47:32]
	input  logic              s_tuser,   // obstacle[0]
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [15:0]       m_tdata,   // duty_level[15:0]
	input  logic              cfg_we,
	input  logic [CfgAW-1:0]  cfg_addr,
	input  logic [CfgDW-1:0]  cfg_data
);

	state_t state_q, state_d;

	// Configuration registers.
	logic [GainW-1:0]   gain_p_q, gain_i_q, gain_d_q;
	logic [LimW-1:0]    int_limit_q;
	logic [DutyW-1:0]   duty_max_q;
	logic [SpeedW-1:0]  speed_thr_q;
	logic [FullSpW-1:0] full_speed_q;

	// Controller state.
	logic signed [SumW-1:0] err_sum_q;
	logic signed [ErrW-1:0] last_err_q;

	// Working registers of one item.
	logic [SpeedW-1:0]       left_q, right_q;
	logic [DutyW-1:0]        rduty_q;
	logic signed [ErrW-1:0]  e_q;
	logic signed [DiffW-1:0] d_q;
	logic signed [ProdW-1:0] prod_q, acc_q;

	// Output register.
	logic              m_valid_q;
	logic [DutyW-1:0]  m_data_q;

	// Shared multiplier.
	logic signed [MulAW-1:0] mul_a;
	logic signed [MulBW-1:0] mul_b;
	logic signed [ProdW-1:0] mul_p;

	logic                    in_acc;
	logic                    out_free;
	logic [SpeedW-1:0]       target;
	logic signed [SumW-1:0]  sum_raw, lim_pos, lim_neg;
	logic [DutyW-1:0]        sat_val;

	assign in_acc   = s_tvalid && s_tready;
	assign out_free = !m_valid_q || m_tready;
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_acc && !s_tuser) state_d = ST_TGT;
			ST_TGT:   state_d = ST_ERR;
			ST_ERR:   state_d = ST_CLAMP;
			ST_CLAMP: state_d = ST_MULP;
			ST_MULP:  state_d = ST_MULI;
			ST_MULI:  state_d = ST_MULD;
			ST_MULD:  state_d = ST_SUM;
			ST_SUM:   state_d = ST_SAT;
			ST_SAT:   if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Handshake and multiplier operand selection.
	always_comb begin
		s_tready = (state_q == ST_IDLE);
		mul_a    = '0;
		mul_b    = '0;
		unique case (state_q)
			ST_TGT: begin
				mul_a = MulAW'(signed'({1'b0, rduty_q}));
				mul_b = MulBW'(signed'({1'b0, full_speed_q}));
			end
			ST_MULP: begin
				mul_a = MulAW'(signed'({1'b0, gain_p_q}));
				mul_b = MulBW'(e_q);
			end
			ST_MULI: begin
				mul_a = MulAW'(signed'({1'b0, gain_i_q}));
				mul_b = MulBW'(err_sum_q);
			end
			ST_MULD: begin
				mul_a = MulAW'(signed'({1'b0, gain_d_q}));
				mul_b = MulBW'(d_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// Target speed: estimate from the right duty when the right wheel is slow.
	assign target = (right_q < speed_thr_q) ? prod_q[SpeedW+7:8] : right_q;

	// Integral update and clamp bounds.
	assign sum_raw = err_sum_q + SumW'(e_q);
	assign lim_pos = SumW'(signed'({1'b0, int_limit_q}));
	assign lim_neg = -lim_pos;

	// Output saturation: negative to zero, large values to duty_max.
	always_comb begin
		if (acc_q[ProdW-1]) begin
			sat_val = '0;
		end else if ((acc_q[ProdW-2:DutyW+4] != '0) || (acc_q[DutyW+3:4] > duty_max_q)) begin
			sat_val = duty_max_q;
		end else begin
			sat_val = acc_q[DutyW+3:4];
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q     <= RstGainP;
			gain_i_q     <= RstGainI;
			gain_d_q     <= RstGainD;
			int_limit_q  <= RstIntLimit;
			duty_max_q   <= RstDutyMax;
			speed_thr_q  <= RstSpeedThr;
			full_speed_q <= RstFullSpeed;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				RegGainP:     gain_p_q     <= cfg_data[GainW-1:0];
				RegGainI:     gain_i_q     <= cfg_data[GainW-1:0];
				RegGainD:     gain_d_q     <= cfg_data[GainW-1:0];
				RegIntLimit:  int_limit_q  <= cfg_data[LimW-1:0];
				RegDutyMax:   duty_max_q   <= cfg_data[DutyW-1:0];
				RegSpeedThr:  speed_thr_q  <= cfg_data[SpeedW-1:0];
				RegFullSpeed: full_speed_q <= cfg_data[FullSpW-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer, controller state and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			err_sum_q  <= '0;
			last_err_q <= '0;
			m_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLAMP) begin
				if (sum_raw > lim_pos) begin
					err_sum_q <= lim_pos;
				end else if (sum_raw < lim_neg) begin
					err_sum_q <= lim_neg;
				end else begin
					err_sum_q <= sum_raw;
				end
				last_err_q <= e_q;
			end
			if (state_q == ST_SAT && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_valid_q && m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			left_q  <= s_tdata[15:0];
			right_q <= s_tdata[31:16];
			rduty_q <= s_tdata[47:32];
		end
		case (state_q)
			ST_TGT:   prod_q <= mul_p;
			ST_ERR:   e_q    <= ErrW'(signed'({1'b0, target}) - signed'({1'b0, left_q}));
			ST_CLAMP: d_q    <= DiffW'(e_q) - DiffW'(last_err_q);
			ST_MULP:  prod_q <= mul_p;
			ST_MULI: begin
				acc_q  <= prod_q;
				prod_q <= mul_p;
			end
			ST_MULD: begin
				acc_q  <= acc_q + prod_q;
				prod_q <= mul_p;
			end
			ST_SUM:   acc_q <= acc_q + prod_q;
			ST_SAT:   if (out_free) m_data_q <= sat_val;
			default: ;
		endcase
	end

	// The integral is inside its bounds once the clamp step is done.
	a_sum_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MULP) |-> (err_sum_q <= lim_pos) && (err_sum_q >= lim_neg))
		else $error("integral outside its limit");

	// A result never exceeds the duty ceiling.
	a_out_ceiling: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q |-> (m_data_q <= duty_max_q))
		else $error("duty level above duty_max");

	// An obstacle transaction leaves the sequencer idle and the state untouched.
	a_obstacle_skip: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && s_tuser) |=> (state_q == ST_IDLE) && $stable(err_sum_q)
			&& $stable(last_err_q))
		else $error("obstacle transaction changed the controller");

	// A result is loaded only from the last sequencer step.
	a_load_from_sat: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_valid_q) |-> ($past(state_q) == ST_SAT))
		else $error("result loaded outside the saturation step");

endmodule
